// File: sv/mpe_pkg.sv
// Shared types and constants for the MPE MIDI event parser.
// Holds the request and result layouts, register indexes and scaling constants.
// No dependencies.
package mpe_pkg;

  localparam int Channels = 16;
  localparam int ChanW    = $clog2(Channels);

  localparam logic [31:0] IdentityReset = 32'd1;
  localparam logic [31:0] IdentityLast  = 32'hFFFF_FFFF;

  localparam logic       ZoneActiveReset   = 1'b1;
  localparam logic [3:0] MemberCountReset  = 4'd15;
  localparam logic [6:0] MemberBendReset   = 7'd48;
  localparam logic [6:0] MasterBendReset   = 7'd2;
  localparam logic [6:0] TimbreCcReset     = 7'd74;
  localparam logic [7:0] TimbreLsbOffset   = 8'd32;

  // Half divisors used for round-to-nearest on odd divisors.
  localparam logic [9:0]  Half7     = 10'd63;
  localparam logic [16:0] Half14    = 17'd8191;
  localparam logic [23:0] HalfBend  = 24'd4095;
  localparam logic [13:0] BendDiv   = 14'd8191;
  localparam logic [13:0] BendCentre = 14'd8192;
  localparam logic [16:0] Unit7Gain = 17'd516;

  typedef enum logic [2:0] {
    CFG_ZONE_ACTIVE  = 3'd0,
    CFG_MEMBER_COUNT = 3'd1,
    CFG_MEMBER_BEND  = 3'd2,
    CFG_MASTER_BEND  = 3'd3,
    CFG_TIMBRE_CC    = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    MSG_NOTE_OFF = 4'h8,
    MSG_NOTE_ON  = 4'h9,
    MSG_CONTROL  = 4'hB,
    MSG_PRESSURE = 4'hD,
    MSG_BEND     = 4'hE
  } msg_type_e;

  typedef enum logic [1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_EXPR     = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    DIM_PITCH    = 2'd0,
    DIM_PRESSURE = 2'd1,
    DIM_TIMBRE   = 2'd2
  } expr_dim_e;

  typedef enum logic [1:0] {
    SC_UNIT7  = 2'd0,
    SC_UNIT14 = 2'd1,
    SC_BEND   = 2'd2
  } scale_sel_e;

  typedef struct packed {
    scale_sel_e  sel;
    logic [13:0] operand;
    logic [6:0]  range;
  } scale_req_t;

  typedef struct packed {
    logic [31:0] frame_stamp;
    logic [1:0]  message_length;
    logic [6:0]  second_data;
    logic [6:0]  first_data;
    logic [7:0]  status_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        event_frame;
    logic signed [23:0] event_value;
    expr_dim_e          expression_dim;
    logic [6:0]         key_number;
    logic [31:0]        note_identity;
    logic [4:0]         channel_number;
    event_kind_e        event_kind;
  } out_item_t;

endpackage

// File: sv/mpe_scale.sv
// Value scaling for the MPE MIDI event parser: 7-bit, 14-bit and pitch bend
// values to signed fixed point with 16 fraction bits, rounded to nearest.
// Depends on mpe_pkg.
module mpe_scale import mpe_pkg::*; (
  input  scale_req_t         req_i,
  output logic signed [23:0] value_o
);

  logic [9:0]  n7;
  logic [2:0]  q7;
  logic [16:0] u7;
  logic [16:0] n14;
  logic [2:0]  q14;
  logic [16:0] u14;
  logic        bend_up;
  logic [13:0] mag;
  logic [20:0] prod;
  logic [23:0] scaled;
  logic [23:0] nb;
  logic [10:0] qb0;
  logic [13:0] rb;
  logic [10:0] qb;
  logic [23:0] bend_val;

  always_comb begin
    // v * 65536 / 127 is 516 v plus 4 v / 127.
    n7  = {1'b0, req_i.operand[6:0], 2'b00} + Half7;
    q7  = 3'(n7 >= 10'd127) + 3'(n7 >= 10'd254) + 3'(n7 >= 10'd381) + 3'(n7 >= 10'd508);
    u7  = 17'(req_i.operand[6:0]) * Unit7Gain + 17'(q7);

    // w * 65536 / 16383 is 4 w plus 4 w / 16383.
    n14 = {1'b0, req_i.operand, 2'b00} + Half14;
    q14 = 3'(n14 >= 17'd16383) + 3'(n14 >= 17'd32766) + 3'(n14 >= 17'd49149)
        + 3'(n14 >= 17'd65532);
    u14 = {1'b0, req_i.operand, 2'b00} + 17'(q14);

    // Above the centre, p * 65536 / 8191 is 8 p plus 8 p / 8191, and the
    // division by 2^13 - 1 folds the high part back into the remainder.
    bend_up  = req_i.operand[13];
    mag      = bend_up ? {1'b0, req_i.operand[12:0]} : BendCentre - req_i.operand;
    prod     = 21'(mag) * 21'(req_i.range);
    scaled   = {prod, 3'b000};
    nb       = scaled + HalfBend;
    qb0      = nb[23:13];
    rb       = 14'(nb[12:0]) + 14'(qb0);
    qb       = qb0 + 11'(rb >= BendDiv);
    bend_val = bend_up ? scaled + 24'(qb) : 24'd0 - scaled;

    unique case (req_i.sel)
      SC_UNIT7:  value_o = signed'(24'(u7));
      SC_UNIT14: value_o = signed'(24'(u14));
      SC_BEND:   value_o = signed'(bend_val);
      default:   value_o = '0;
    endcase
  end

endmodule

// File: sv/mpe_midi_event_parser.sv
// Top level of the MPE MIDI event parser (lower zone).
// Depends on mpe_pkg and mpe_scale.
//
// The parser takes one complete MIDI channel message per request and returns
// at most one note-on, note-off or note-expression event. A request is taken
// every cycle when the output side keeps up; each request is held in the
// input register until the result register can take it and then moves there,
// from which its event is offered on the output. Per-channel note ids,
// keys and timbre MSBs live in a 16-entry register file that is read and
// updated in the same cycle, so back-to-back messages on one channel see
// each other's effect.
// Configuration writes are taken at any time and must only happen while idle.
module mpe_midi_event_parser import mpe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [6:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // status_byte[7:0], first_data[14:8], second_data[21:15],
  // message_length[23:22], frame_stamp[55:24]
  input  logic [55:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // event_kind[1:0], channel_number[6:2], note_identity[38:7], key_number[45:39],
  // expression_dim[47:46], event_value[71:48], event_frame[103:72]
  output logic [103:0] m_axis_tdata_o
);

  logic       zone_q;
  logic [3:0] member_count_q;
  logic [6:0] member_bend_q;
  logic [6:0] master_bend_q;
  logic [6:0] timbre_cc_q;

  logic        in_valid_q;
  in_item_t    in_q;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        advance;

  logic [31:0] held_id_q [Channels];
  logic [31:0] held_id_d [Channels];
  logic [6:0]  held_key_q [Channels];
  logic [6:0]  held_key_d [Channels];
  logic [6:0]  msb_val_q [Channels];
  logic [6:0]  msb_val_d [Channels];
  logic [Channels-1:0] msb_seen_q;
  logic [Channels-1:0] msb_seen_d;
  logic [31:0] next_id_q;
  logic [31:0] next_id_d;

  logic [ChanW-1:0]   ch;
  logic               member;
  logic               emit;
  event_kind_e        kind;
  expr_dim_e          dim;
  logic [31:0]        id;
  logic [6:0]         key;
  scale_req_t         sreq;
  logic signed [23:0] svalue;
  logic               is_long;
  logic               key_match;
  logic [7:0]         lsb_cc;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  mpe_scale u_scale (
    .req_i   (sreq),
    .value_o (svalue)
  );

  always_comb begin
    ch        = in_q.status_byte[ChanW-1:0];
    member    = zone_q && (ch != '0) && (ch <= member_count_q);
    is_long   = in_q.message_length == 2'd3;
    key_match = held_key_q[ch] == in_q.first_data;
    lsb_cc    = {1'b0, timbre_cc_q} + TimbreLsbOffset;

    emit      = 1'b0;
    kind      = EV_EXPR;
    dim       = DIM_PITCH;
    id        = member ? held_id_q[ch] : '0;
    key       = '0;
    sreq.sel     = SC_UNIT7;
    sreq.operand = {7'd0, in_q.second_data};
    sreq.range   = member ? member_bend_q : master_bend_q;

    held_id_d  = held_id_q;
    held_key_d = held_key_q;
    msb_val_d  = msb_val_q;
    msb_seen_d = msb_seen_q;
    next_id_d  = next_id_q;

    if (in_q.message_length >= 2'd2 && in_q.status_byte[7] && in_q.status_byte[7:4] != 4'hF) begin
      unique case (msg_type_e'(in_q.status_byte[7:4]))
        MSG_NOTE_OFF, MSG_NOTE_ON: begin
          if (is_long) begin
            emit = 1'b1;
            key  = in_q.first_data;
            if (in_q.status_byte[7:4] == MSG_NOTE_OFF || in_q.second_data == '0) begin
              kind = EV_NOTE_OFF;
              id   = key_match ? held_id_q[ch] : '0;
              if (key_match) begin
                held_id_d[ch]  = '0;
                held_key_d[ch] = '0;
              end
            end else begin
              kind           = EV_NOTE_ON;
              id             = next_id_q;
              held_id_d[ch]  = next_id_q;
              held_key_d[ch] = in_q.first_data;
              if (next_id_q != IdentityLast) begin
                next_id_d = next_id_q + 32'd1;
              end
            end
          end
        end
        MSG_BEND: begin
          emit         = is_long;
          sreq.sel     = SC_BEND;
          sreq.operand = {in_q.second_data, in_q.first_data};
        end
        MSG_PRESSURE: begin
          emit         = 1'b1;
          dim          = DIM_PRESSURE;
          sreq.operand = {7'd0, in_q.first_data};
        end
        MSG_CONTROL: begin
          dim = DIM_TIMBRE;
          if (is_long) begin
            if ({1'b0, in_q.first_data} == lsb_cc) begin
              emit         = msb_seen_q[ch];
              sreq.sel     = SC_UNIT14;
              sreq.operand = {msb_val_q[ch], in_q.second_data};
            end else if (in_q.first_data == timbre_cc_q) begin
              emit           = 1'b1;
              msb_val_d[ch]  = in_q.second_data;
              msb_seen_d[ch] = 1'b1;
            end
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q         <= ZoneActiveReset;
      member_count_q <= MemberCountReset;
      member_bend_q  <= MemberBendReset;
      master_bend_q  <= MasterBendReset;
      timbre_cc_q    <= TimbreCcReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_ZONE_ACTIVE:  zone_q         <= cfg_wdata_i[0];
        CFG_MEMBER_COUNT: member_count_q <= cfg_wdata_i[3:0];
        CFG_MEMBER_BEND:  member_bend_q  <= cfg_wdata_i;
        CFG_MASTER_BEND:  master_bend_q  <= cfg_wdata_i;
        CFG_TIMBRE_CC:    timbre_cc_q    <= cfg_wdata_i;
        default:          zone_q         <= zone_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_id_q  <= '{default: '0};
      held_key_q <= '{default: '0};
      msb_val_q  <= '{default: '0};
      msb_seen_q <= '0;
      next_id_q  <= IdentityReset;
    end else if (advance) begin
      held_id_q  <= held_id_d;
      held_key_q <= held_key_d;
      msb_val_q  <= msb_val_d;
      msb_seen_q <= msb_seen_d;
      next_id_q  <= next_id_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= emit;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= in_item_t'(s_axis_tdata_i);
    end
    if (advance && emit) begin
      out_q.event_kind     <= kind;
      out_q.channel_number <= 5'(ch) + 5'd1;
      out_q.note_identity  <= id;
      out_q.key_number     <= key;
      out_q.expression_dim <= dim;
      out_q.event_value    <= svalue;
      out_q.event_frame    <= in_q.frame_stamp;
    end
  end

endmodule
